@@ rtl/assert_macros.svh @@
// Assertion macros shared by the host name extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define SNI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define SNI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sni_pkg.sv @@
// Shared types and constants of the server name host name extractor.
`default_nettype none

package sni_pkg;

  // default width of the length counters
  localparam int LENGTH_BITS_DEF = 16;

  // stream word widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // protocol constants
  localparam logic [7:0] HOST_ENTRY_TYPE = 8'd0;
  localparam int         ENTRY_HEADER    = 3;
  localparam int         LIST_HEADER     = 2;

  // output word bit positions
  localparam int OUT_NAME_END_BIT = 8;
  localparam int OUT_FOUND_BIT    = 9;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LIST_LO = 7'b0000010,
    PH_TYPE    = 7'b0000100,
    PH_NLEN_HI = 7'b0001000,
    PH_NLEN_LO = 7'b0010000,
    PH_NAME    = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

  // per-word outcome of the parser
  typedef struct packed {
    logic has_result;
    logic name_valid;
    logic name_end;
    logic done;
    logic found;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/sni_parse.sv @@
// Parser state and per-byte next-state logic of the host name extractor.
`default_nettype none

module sni_parse #(
  parameter int LENGTH_BITS = sni_pkg::LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first,
  input  wire logic [15:0]       ext_length,
  input  wire logic              last,
  output sni_pkg::res_t          res
);
  import sni_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int CW = (LB > 16) ? LB : 16;
  localparam logic [CW-1:0] LEN_MAX = CW'({LB{1'b1}});

  phase_t          phase_r, phase_nxt;
  logic [LB-1:0]   bytes_total_r, bytes_total_nxt;
  logic [LB-1:0]   list_left_r, list_left_nxt;
  logic [7:0]      length_high_r, length_high_nxt;
  logic [7:0]      entry_kind_r, entry_kind_nxt;
  logic [LB-1:0]   name_left_r, name_left_nxt;
  logic            name_seen_r, name_seen_nxt;

  logic [CW-1:0]   ext_sat;
  logic [15:0]     len16;
  logic [LB-1:0]   bt_dec;
  logic [LB-1:0]   ll_dec;
  logic [LB-1:0]   nl_dec;
  logic            valid;
  logic            nend;
  logic            scan_hdr;

  assign scan_hdr = (phase_r == PH_TYPE) || (phase_r == PH_NLEN_HI) || (phase_r == PH_NLEN_LO);

  always_comb begin
    phase_nxt       = phase_r;
    bytes_total_nxt = bytes_total_r;
    list_left_nxt   = list_left_r;
    length_high_nxt = length_high_r;
    entry_kind_nxt  = entry_kind_r;
    name_left_nxt   = name_left_r;
    name_seen_nxt   = name_seen_r;
    valid           = 1'b0;
    nend            = 1'b0;

    ext_sat = (CW'(ext_length) > LEN_MAX) ? LEN_MAX : CW'(ext_length);
    len16   = {length_high_r, data_byte};
    bt_dec  = (bytes_total_r != '0) ? bytes_total_r - LB'(1) : '0;
    ll_dec  = list_left_r - LB'(1);
    nl_dec  = (name_left_r != '0) ? name_left_r - LB'(1) : '0;

    if (first) begin
      name_seen_nxt = 1'b0;
      if (ext_sat < CW'(LIST_HEADER)) begin
        bytes_total_nxt = '0;
        phase_nxt       = PH_IDLE;
      end else begin
        bytes_total_nxt = LB'(ext_sat - CW'(1));
        length_high_nxt = data_byte;
        phase_nxt       = PH_LIST_LO;
      end
    end else begin
      bytes_total_nxt = bt_dec;
      case (phase_r)
        PH_LIST_LO: begin
          // clamp the list to what the extension still holds
          list_left_nxt = (CW'(len16) < CW'(bt_dec)) ? LB'(len16) : bt_dec;
          phase_nxt = (CW'(list_left_nxt) >= CW'(ENTRY_HEADER)) ? PH_TYPE : PH_IDLE;
        end
        PH_TYPE: begin
          entry_kind_nxt = data_byte;
          list_left_nxt  = ll_dec;
          phase_nxt      = PH_NLEN_HI;
        end
        PH_NLEN_HI: begin
          length_high_nxt = data_byte;
          list_left_nxt   = ll_dec;
          phase_nxt       = PH_NLEN_LO;
        end
        PH_NLEN_LO: begin
          list_left_nxt = ll_dec;
          if (CW'(len16) > CW'(ll_dec)) begin
            phase_nxt = PH_IDLE;
          end else if (entry_kind_r == HOST_ENTRY_TYPE) begin
            name_seen_nxt = 1'b1;
            name_left_nxt = LB'(len16);
            phase_nxt     = (len16 == '0) ? PH_IDLE : PH_NAME;
          end else begin
            list_left_nxt = ll_dec - LB'(len16);
            name_left_nxt = LB'(len16);
            if (len16 == '0) begin
              phase_nxt = (CW'(list_left_nxt) >= CW'(ENTRY_HEADER)) ? PH_TYPE : PH_IDLE;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_NAME: begin
          valid         = 1'b1;
          name_left_nxt = nl_dec;
          if (nl_dec == '0) begin
            nend      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SKIP: begin
          name_left_nxt = nl_dec;
          if (nl_dec == '0) begin
            phase_nxt = (CW'(list_left_r) >= CW'(ENTRY_HEADER)) ? PH_TYPE : PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (last) begin
      phase_nxt = PH_IDLE;
    end

    res.has_result = valid | last;
    res.name_valid = valid;
    res.name_end   = nend;
    res.done       = last;
    res.found      = last & name_seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_total_r <= '0;
      list_left_r   <= '0;
      length_high_r <= '0;
      entry_kind_r  <= '0;
      name_left_r   <= '0;
      name_seen_r   <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bytes_total_r <= bytes_total_nxt;
      list_left_r   <= list_left_nxt;
      length_high_r <= length_high_nxt;
      entry_kind_r  <= entry_kind_nxt;
      name_left_r   <= name_left_nxt;
      name_seen_r   <= name_seen_nxt;
    end
  end

`include "assert_macros.svh"

  `SNI_ASSERT(a_name_marks_seen, step && res.name_valid |=> name_seen_r, "name byte before entry")
  `SNI_ASSERT(a_list_in_ext, scan_hdr |-> CW'(list_left_r) <= CW'(bytes_total_r), "scan overrun")

endmodule

`default_nettype wire

@@ rtl/sni_host_name_extractor.sv @@
// Top level of the TLS server name host name extractor.
`default_nettype none

// The block takes a TLS server name extension one byte per input word and
// passes out the bytes of the first host name entry if its name fits in
// the list, then a closing word on the byte marked tlast with done and found.
// Mark the first byte of each extension with in_tuser and carry the total
// extension length beside it; a first byte restarts parsing at any point.
// Bytes seen before any first byte are ignored, but a tlast byte still
// reports done with the previous extension's found bit. An empty extension
// must not be sent. A word lands in an input register, one parse step
// updates the length counters between that register and the output
// register, and a new byte is taken every cycle while the output side
// keeps up. Bytes that produce no result (headers, skipped entries,
// trailing bytes) give no output word. The output register holds its
// word under back pressure while the input register still takes one
// more byte. LENGTH_BITS sets the width of the byte counters; longer
// extension lengths saturate.
module sni_host_name_extractor #(
  parameter int LENGTH_BITS = sni_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [sni_pkg::IN_TDATA_W-1:0]   in_tdata,   // data_byte[7:0], ext_length[23:8]
  input  wire logic                             in_tuser,   // first
  input  wire logic                             in_tlast,   // last
  // result stream
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [sni_pkg::OUT_TDATA_W-1:0]  out_tdata,  // name_byte[7:0], name_end[8],
                                                            // found[9], zero[15:10]
  output      logic                             out_tuser,  // name_valid
  output      logic                             out_tlast   // done_res
);
  import sni_pkg::*;

  // input register
  logic        s1_v_r, s1_v_nxt;
  logic [7:0]  s1_byte_r;
  logic [15:0] s1_ext_r;
  logic        s1_first_r;
  logic        s1_last_r;

  // output register
  logic        out_v_r, out_v_nxt;
  logic [7:0]  out_byte_r;
  logic        out_end_r;
  logic        out_found_r;
  logic        out_valid_r;
  logic        out_done_r;

  logic        in_fire;
  logic        adv;
  res_t        res;

  // advance the held byte whenever the output register is free or draining
  assign adv       = s1_v_r & (~out_v_r | out_tready);
  assign in_tready = ~s1_v_r | adv;
  assign in_fire   = in_tvalid & in_tready;

  sni_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .data_byte  (s1_byte_r),
    .first      (s1_first_r),
    .ext_length (s1_ext_r),
    .last       (s1_last_r),
    .res        (res)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv && res.has_result) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // hold the input word until the parser takes it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_ext_r   <= in_tdata[23:8];
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // load a result only when the step produces one
  always_ff @(posedge clk) begin
    if (adv && res.has_result) begin
      out_byte_r  <= res.name_valid ? s1_byte_r : 8'd0;
      out_valid_r <= res.name_valid;
      out_end_r   <= res.name_end;
      out_done_r  <= res.done;
      out_found_r <= res.found;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FOUND_BIT - 1)'(0), out_found_r, out_end_r,
                       out_byte_r};
  assign out_tuser  = out_valid_r;
  assign out_tlast  = out_done_r;

`include "assert_macros.svh"

  `SNI_ASSERT_RST(a_reset_empties, !rst_n |=> !out_tvalid && !s1_v_r, "not empty after reset")
  `SNI_ASSERT(a_take_holds, in_tvalid && in_tready |=> s1_v_r, "accepted word lost")
  `SNI_ASSERT(a_end_is_name, out_tvalid && out_tdata[OUT_NAME_END_BIT] |-> out_tuser, "stray end")
  `SNI_ASSERT(a_found_with_done, out_tvalid && out_tdata[OUT_FOUND_BIT] |-> out_tlast, "stray found")

endmodule

`default_nettype wire

@@ tb/sni_name_checker.sv @@
// Checker for the host name extractor: predicts output words and compares them.
`timescale 1ns / 1ps

module sni_name_checker
  import sni_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], ext_length[23:8]
  input  logic                   in_tuser,   // first
  input  logic                   in_tlast,   // last
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // name_byte[7:0], name_end[8], found[9], zero[15:10]
  input  logic                   out_tuser,  // name_valid
  input  logic                   out_tlast,  // done_res
  output int                     fail_count,
  output int                     pending
);

  localparam int LB = LENGTH_BITS_DEF;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_valid;
    logic       name_end;
    logic       done;
    logic       found;
  } name_word_t;

  // parser state mirrored from the input side
  phase_t        scan_ph;
  logic [LB-1:0] left_total;
  logic [LB-1:0] scan_left;
  logic [7:0]    len_hi;
  logic [7:0]    entry_type;
  logic [LB-1:0] name_left;
  logic          host_seen;

  name_word_t    name_words_q[$];
  int            shown;

  function automatic phase_t next_entry_ph(input logic [LB-1:0] left);
    return (left >= ENTRY_HEADER) ? PH_TYPE : PH_IDLE;
  endfunction

  always @(posedge clk) begin
    logic [7:0]    b;
    logic [15:0]   ext;
    logic [LB-1:0] len;
    logic          hit;
    logic          bad;
    name_word_t    w;
    name_word_t    got;

    if (!rst_n) begin
      scan_ph    = PH_IDLE;
      left_total = '0;
      scan_left  = '0;
      len_hi     = '0;
      entry_type = '0;
      name_left  = '0;
      host_seen  = 1'b0;
      shown      = 0;
      name_words_q.delete();
      fail_count <= 0;
    end else begin
      // compare a delivered word against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tuser, out_tdata[OUT_NAME_END_BIT], out_tlast,
                out_tdata[OUT_FOUND_BIT]};
        if (name_words_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10)
            $display("%0t: unexpected word byte=%02h valid=%b end=%b done=%b found=%b",
                     $realtime, got.name_byte, got.name_valid, got.name_end, got.done,
                     got.found);
          shown++;
        end else begin
          w = name_words_q.pop_front();
          bad = (got.name_byte !== w.name_byte) || (got.name_valid !== w.name_valid) ||
                (got.name_end !== w.name_end) || (got.done !== w.done) ||
                (got.found !== w.found) || (out_tdata[15:10] !== 6'd0);
          if (bad) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("%0t: mismatch exp byte=%02h valid=%b end=%b done=%b found=%b",
                       $realtime, w.name_byte, w.name_valid, w.name_end, w.done, w.found,
                       " | got byte=%02h valid=%b end=%b done=%b found=%b pad=%02h",
                       got.name_byte, got.name_valid, got.name_end, got.done, got.found,
                       out_tdata[15:10]);
            shown++;
          end
        end
      end

      // advance the parser by one accepted byte
      if (in_tvalid && in_tready) begin
        b   = in_tdata[7:0];
        ext = in_tdata[23:8];
        w   = '0;
        if (in_tuser) begin
          host_seen = 1'b0;
          if (ext < LIST_HEADER) begin
            left_total = '0;
            scan_ph    = PH_IDLE;
          end else begin
            left_total = ext - 1'b1;
            len_hi     = b;
            scan_ph    = PH_LIST_LO;
          end
        end else begin
          if (left_total != 0)
            left_total--;
          case (scan_ph)
            PH_LIST_LO: begin
              len       = {len_hi, b};
              scan_left = (len < left_total) ? len : left_total;
              scan_ph   = next_entry_ph(scan_left);
            end
            PH_TYPE: begin
              entry_type = b;
              scan_left--;
              scan_ph = PH_NLEN_HI;
            end
            PH_NLEN_HI: begin
              len_hi = b;
              scan_left--;
              scan_ph = PH_NLEN_LO;
            end
            PH_NLEN_LO: begin
              len = {len_hi, b};
              scan_left--;
              if (len > scan_left) begin
                scan_ph = PH_IDLE;  // overlong entry ends the scan
              end else if (entry_type == HOST_ENTRY_TYPE) begin
                host_seen = 1'b1;
                name_left = len;
                scan_ph   = (len == 0) ? PH_IDLE : PH_NAME;
              end else begin
                scan_left = scan_left - len;
                name_left = len;
                scan_ph   = (len == 0) ? next_entry_ph(scan_left) : PH_SKIP;
              end
            end
            PH_NAME: begin
              w.name_valid = 1'b1;
              w.name_byte  = b;
              if (name_left != 0)
                name_left--;
              if (name_left == 0) begin
                w.name_end = 1'b1;
                scan_ph    = PH_IDLE;
              end
            end
            PH_SKIP: begin
              if (name_left != 0)
                name_left--;
              if (name_left == 0)
                scan_ph = next_entry_ph(scan_left);
            end
            default: scan_ph = PH_IDLE;
          endcase
        end
        if (in_tlast) begin
          scan_ph = PH_IDLE;
          w.done  = 1'b1;
          w.found = host_seen;
        end
        hit = w.name_valid || w.done;
        if (hit)
          name_words_q.insert(name_words_q.size(), w);
      end
    end
    pending <= name_words_q.size();
  end

endmodule

@@ tb/tb_sni_host_name_extractor.sv @@
// Testbench top for the host name extractor: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sni_host_name_extractor;
  import sni_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_byte[7:0], ext_length[23:8]
  logic                   in_tuser;   // first
  logic                   in_tlast;   // last
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // name_byte[7:0], name_end[8], found[9], zero[15:10]
  logic                   out_tuser;  // name_valid
  logic                   out_tlast;  // done_res

  int   fail_count;
  int   pending;
  int   burst_left;
  int   sent_items;
  logic hold_req;

  sni_host_name_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sni_name_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one word; start a new burst with a random gap when the current one
  // runs out. Return at the edge where the word was taken.
  task automatic put_word(input logic [7:0] data, input logic first, input logic [15:0] ext,
                          input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {ext, data};
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send one extension: first on byte zero with its length, last optional on
  // the final byte, random length field on the other bytes.
  task automatic send_ext(input byte_q_t bytes, input logic [15:0] ext_len,
                          input logic with_last);
    for (int i = 0; i < bytes.size(); i++)
      put_word(bytes[i], i == 0, (i == 0) ? ext_len : 16'($urandom),
               with_last && (i == bytes.size() - 1));
    sent_items += bytes.size();
  endtask

  // Receiver: stall density changes per window, with one long hold-off on
  // request so the block backs up and stalls its input.
  initial begin
    int stall_pct;
    int win_left;
    int hold_cnt;
    bit hold_done;
    stall_pct  = 0;
    win_left   = 0;
    hold_cnt   = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (win_left == 0) begin
        win_left = $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end
      win_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_sni_host_name_extractor: errors");
    $finish;
  end

  initial begin
    byte_q_t     bytes;
    byte_q_t     list;
    logic [15:0] ext_len;
    logic [15:0] list_len;
    logic [15:0] decl_len;
    logic [7:0]  kind;
    logic        with_last;
    int          n_ent;
    int          nlen;
    bit          hold_sent;
    bit          pause_sent;

    hold_sent  = 1'b0;
    pause_sent = 1'b0;
    burst_left = 0;
    sent_items = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    hold_req   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // stray last byte before any extension: done with found clear
    put_word(8'hFF, 1'b0, 16'hFFFF, 1'b1);
    // short extensions: length zero and one, single byte with first and last
    bytes = {8'h00};
    send_ext(bytes, 16'd0, 1'b1);
    bytes = {8'hFF};
    send_ext(bytes, 16'd1, 1'b1);
    // plain host name entry, name bytes at both extremes
    bytes = {8'h00, 8'h05, HOST_ENTRY_TYPE, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_ext(bytes, 16'd7, 1'b1);
    // empty entry of another type skipped, then an empty host name counts as found
    bytes = {8'h00, 8'h06, 8'h07, 8'h00, 8'h00, HOST_ENTRY_TYPE, 8'h00, 8'h00};
    send_ext(bytes, 16'd8, 1'b1);
    // overlong entry under the largest extension length, cut by an early last
    bytes = {8'h00, 8'h03, HOST_ENTRY_TYPE, 8'h00, 8'h09};
    send_ext(bytes, 16'hFFFF, 1'b1);

    // --- random part: mostly well-formed lists with random content ---
    while (sent_items < ITEM_TARGET) begin
      // long receiver hold-off while a long host name keeps coming
      if (!hold_sent && sent_items > 600) begin
        hold_sent = 1'b1;
        hold_req <= 1'b1;
        bytes = {8'h00, 8'd51, HOST_ENTRY_TYPE, 8'h00, 8'd48};
        repeat (48) bytes.insert(bytes.size(), 8'($urandom));
        send_ext(bytes, 16'd53, 1'b1);
      end
      // let everything drain once before going on
      if (!pause_sent && sent_items > 1200) begin
        pause_sent = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end

      // stray words outside any extension
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 3))
          put_word(8'($urandom), 1'b0, 16'($urandom), $urandom_range(0, 3) == 0);
      end

      list.delete();
      n_ent = $urandom_range(0, 4);
      for (int e = 0; e < n_ent; e++) begin
        kind = ($urandom_range(0, 9) < 6) ? HOST_ENTRY_TYPE : 8'($urandom_range(1, 255));
        nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        decl_len = 16'(nlen);
        if ($urandom_range(0, 15) == 0)
          decl_len = decl_len + 16'($urandom_range(1, 300));
        list.insert(list.size(), kind);
        list.insert(list.size(), decl_len[15:8]);
        list.insert(list.size(), decl_len[7:0]);
        repeat (nlen) list.insert(list.size(), 8'($urandom));
      end

      list_len = 16'(list.size());
      case ($urandom_range(0, 15))
        0: list_len = 16'($urandom);
        1: list_len = 16'($urandom_range(0, 4));
        2: list_len = list_len + 16'($urandom_range(1, 5));
        3: if (list_len > 0) list_len = list_len - 16'($urandom_range(1, list_len));
        default: ;
      endcase

      bytes = {list_len[15:8], list_len[7:0]};
      foreach (list[k]) bytes.insert(bytes.size(), list[k]);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) bytes.insert(bytes.size(), 8'($urandom));

      ext_len = 16'(bytes.size());
      case ($urandom_range(0, 15))
        0: ext_len = 16'($urandom);
        1: ext_len = ext_len - 16'($urandom_range(1, bytes.size()));
        default: ;
      endcase

      // early last: cut the extension short
      if ($urandom_range(0, 7) == 0)
        bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
      // a missing last leaves the next first to restart parsing
      with_last = ($urandom_range(0, 15) != 0);
      send_ext(bytes, ext_len, with_last);
    end

    // --- wind down ---
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_sni_host_name_extractor: clean");
    else
      $display("tb_sni_host_name_extractor: errors");
    $finish;
  end

endmodule
